// ===== design/cle_pkg.sv =====
// ----------------------------------------------------------------------------
// cle_pkg: shared types and constants for the cursor line editor
// Beat payloads, edit key codes, controller-to-datapath command and status.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cle_pkg;

   localparam int LINE_DEPTH_DEF = 64;

   localparam logic [7:0] KEY_LEFT  = 8'h3C;
   localparam logic [7:0] KEY_RIGHT = 8'h3E;
   localparam logic [7:0] KEY_BACK  = 8'h2D;

   typedef struct packed {
      logic       action;
      logic [7:0] key_code;
   } req_type;

   typedef struct packed {
      logic [7:0] char_out;
      logic       last;
      logic       empty_line;
      logic       overflowed;
   } rsp_type;

   // datapath operations
   localparam int OP_W = 4;
   localparam logic [OP_W-1:0] OP_NONE     = 4'd0;
   localparam logic [OP_W-1:0] OP_INSERT   = 4'd1;
   localparam logic [OP_W-1:0] OP_BACK     = 4'd2;
   localparam logic [OP_W-1:0] OP_OVF      = 4'd3;
   localparam logic [OP_W-1:0] OP_LEFT_RD  = 4'd4;
   localparam logic [OP_W-1:0] OP_LEFT_WR  = 4'd5;
   localparam logic [OP_W-1:0] OP_RIGHT_RD = 4'd6;
   localparam logic [OP_W-1:0] OP_RIGHT_WR = 4'd7;
   localparam logic [OP_W-1:0] OP_EMIT_RD  = 4'd8;
   localparam logic [OP_W-1:0] OP_EMIT_LD  = 4'd9;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [7:0]      key;
   } cmd_type;

   typedef struct packed {
      logic left_zero;
      logic right_zero;
      logic full;
      logic last_beat;
      logic out_free;
   } stat_type;

endpackage

// ===== design/cle_ctrl.sv =====
// ----------------------------------------------------------------------------
// cle_ctrl: controller for the cursor line editor
// Decodes keystrokes and sequences cursor moves and line emission.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  cle_pkg::req_type  req_data,
   output logic              req_stall,
   input  cle_pkg::stat_type stat,
   output cle_pkg::cmd_type  cmd
);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_MOVE_L  = 3'd1;
   localparam logic [2:0] ST_MOVE_R  = 3'd2;
   localparam logic [2:0] ST_EMIT_RD = 3'd3;
   localparam logic [2:0] ST_EMIT_LD = 3'd4;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd.op   = cle_pkg::OP_NONE;
      cmd.key  = req_data.key_code;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_data.action) begin
                  state_in = ST_EMIT_RD;
               end else if (req_data.key_code == cle_pkg::KEY_LEFT) begin
                  if (!stat.left_zero) begin
                     cmd.op   = cle_pkg::OP_LEFT_RD;
                     state_in = ST_MOVE_L;
                  end
               end else if (req_data.key_code == cle_pkg::KEY_RIGHT) begin
                  if (!stat.right_zero) begin
                     cmd.op   = cle_pkg::OP_RIGHT_RD;
                     state_in = ST_MOVE_R;
                  end
               end else if (req_data.key_code == cle_pkg::KEY_BACK) begin
                  if (!stat.left_zero) cmd.op = cle_pkg::OP_BACK;
               end else if (stat.full) begin
                  cmd.op = cle_pkg::OP_OVF;
               end else begin
                  cmd.op = cle_pkg::OP_INSERT;
               end
            end
         end
         ST_MOVE_L: begin
            cmd.op   = cle_pkg::OP_LEFT_WR;
            state_in = ST_IDLE;
         end
         ST_MOVE_R: begin
            cmd.op   = cle_pkg::OP_RIGHT_WR;
            state_in = ST_IDLE;
         end
         ST_EMIT_RD: begin
            cmd.op   = cle_pkg::OP_EMIT_RD;
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            // wait for the output register to free up
            if (stat.out_free) begin
               cmd.op   = cle_pkg::OP_EMIT_LD;
               state_in = stat.last_beat ? ST_IDLE : ST_EMIT_RD;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== design/cle_datapath.sv =====
// ----------------------------------------------------------------------------
// cle_datapath: gap buffer storage, counts and output register
// Left text at 0..left-1, right text at DEPTH-right..DEPTH-1.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_datapath #(
   parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  cle_pkg::cmd_type  cmd,
   output cle_pkg::stat_type stat,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cle_pkg::rsp_type  rsp_data
);

   localparam int CW = $clog2(LINE_DEPTH + 1);
   localparam int AW = $clog2(LINE_DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(LINE_DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   logic [7:0] mem [LINE_DEPTH];

   logic [CW-1:0]    left_ff, left_in;
   logic [CW-1:0]    right_ff, right_in;
   logic [CW-1:0]    idx_ff, idx_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rd_data_ff;
   cle_pkg::rsp_type rsp_ff;

   logic [CW-1:0] total;
   logic          empty;
   logic          rd_en, wr_en;
   logic [CW-1:0] rd_addr, wr_addr;
   logic [7:0]    wr_data;

   assign total = left_ff + right_ff;
   assign empty = (total == '0);

   assign stat.left_zero  = (left_ff == '0);
   assign stat.right_zero = (right_ff == '0);
   assign stat.full       = (total == DEPTH_C);
   assign stat.last_beat  = empty || (idx_ff + ONE_C == total);
   assign stat.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // memory port addressing
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      wr_en   = 1'b0;
      wr_addr = left_ff;
      wr_data = rd_data_ff;
      case (cmd.op)
         cle_pkg::OP_LEFT_RD: begin
            rd_en   = 1'b1;
            rd_addr = left_ff - ONE_C;
         end
         cle_pkg::OP_RIGHT_RD: begin
            rd_en   = 1'b1;
            rd_addr = DEPTH_C - right_ff;
         end
         cle_pkg::OP_EMIT_RD: begin
            rd_en   = 1'b1;
            // skip the gap once past the cursor
            rd_addr = (idx_ff < left_ff) ? idx_ff : idx_ff + (DEPTH_C - total);
         end
         cle_pkg::OP_INSERT: begin
            wr_en   = 1'b1;
            wr_data = cmd.key;
         end
         cle_pkg::OP_LEFT_WR: begin
            wr_en   = 1'b1;
            wr_addr = DEPTH_C - right_ff - ONE_C;
         end
         cle_pkg::OP_RIGHT_WR: begin
            wr_en = 1'b1;
         end
         default: begin
            rd_en = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr[AW-1:0]] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (rd_en) rd_data_ff <= mem[rd_addr[AW-1:0]];
   end

   // counts and output beat
   always_comb begin
      left_in      = left_ff;
      right_in     = right_ff;
      idx_in       = idx_ff;
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (cmd.op)
         cle_pkg::OP_INSERT: left_in = left_ff + ONE_C;
         cle_pkg::OP_BACK:   left_in = left_ff - ONE_C;
         cle_pkg::OP_OVF:    ovf_in  = 1'b1;
         cle_pkg::OP_LEFT_WR: begin
            left_in  = left_ff - ONE_C;
            right_in = right_ff + ONE_C;
         end
         cle_pkg::OP_RIGHT_WR: begin
            left_in  = left_ff + ONE_C;
            right_in = right_ff - ONE_C;
         end
         cle_pkg::OP_EMIT_LD: begin
            rsp_valid_in = 1'b1;
            idx_in       = idx_ff + ONE_C;
            if (stat.last_beat) begin
               left_in  = '0;
               right_in = '0;
               idx_in   = '0;
               ovf_in   = 1'b0;
            end
         end
         default: begin
            left_in = left_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff      <= '0;
         right_ff     <= '0;
         idx_ff       <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         left_ff      <= left_in;
         right_ff     <= right_in;
         idx_ff       <= idx_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == cle_pkg::OP_EMIT_LD) begin
         rsp_ff.char_out   <= empty ? 8'h00 : rd_data_ff;
         rsp_ff.last       <= stat.last_beat;
         rsp_ff.empty_line <= empty;
         rsp_ff.overflowed <= ovf_ff;
      end
   end

endmodule

// ===== design/cursor_line_editor_top.sv =====
// ----------------------------------------------------------------------------
// cursor_line_editor_top: gap buffer line editor with cursor
// Keystroke beats edit one line; an end-of-line beat streams it out.
// ----------------------------------------------------------------------------
//  channel  | ports                             | direction
//  request  | req_valid, req_stall, req_data    | in  (action, key_code)
//  response | rsp_valid, rsp_stall, rsp_data    | out (char_out, last, empty_line,
//           |                                   |      overflowed)
//
//  Insert, backspace and no-op keys are done from the idle state; cursor moves
//  read memory, then write the character across the gap through the write port.
//  End of line does one read and one load of the output register per
//  character (one of each for an empty line), waiting while a stalled beat holds it.
//  Synchronous active-high reset clears counts and flags; no clearing pass.
//  The output register lets keystrokes be taken while a beat waits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_line_editor_top #(
   parameter int LINE_DEPTH = cle_pkg::LINE_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  cle_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output cle_pkg::rsp_type rsp_data
);

   cle_pkg::cmd_type  cmd;
   cle_pkg::stat_type stat;

   cle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   cle_datapath #(
      .LINE_DEPTH (LINE_DEPTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== design/cle_checker.sv =====
// ----------------------------------------------------------------------------
// cle_checker: port-level checks for the cursor line editor
// Watches both channels; bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cle_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input cle_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input cle_pkg::rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   a_empty_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_line |-> rsp_data.last && rsp_data.char_out == 8'h00)
      else $error("empty line beat malformed");

   a_eol_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.action |=> req_stall)
      else $error("request taken during line emission");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind cursor_line_editor_top cle_checker u_cle_checker (.*);

// ===== dv/cursor_line_editor_top_test.sv =====
// ----------------------------------------------------------------------------
// cursor_line_editor_top_test: self-checking bench for the gap buffer editor
// A short table of keystroke and end-of-line beats, then random lines, runs
// against a gap buffer predictor. Every response beat is checked field by
// field in order. Both channels idle and stall at random, and one long
// response hold-off backs the block up into its request channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cursor_line_editor_top_test;

   localparam int LINE_DEPTH   = cle_pkg::LINE_DEPTH_DEF;
   localparam int RANDOM_BEATS = 320;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 160;

   localparam logic ACT_KEY = 1'b0;
   localparam logic ACT_EOL = 1'b1;

   localparam cle_pkg::rsp_type RSP_EMPTY =
      '{char_out: 8'h00, last: 1'b1, empty_line: 1'b1, overflowed: 1'b0};
   localparam cle_pkg::rsp_type RSP_ONE_00 =
      '{char_out: 8'h00, last: 1'b1, empty_line: 1'b0, overflowed: 1'b0};
   localparam cle_pkg::rsp_type RSP_ONE_FF =
      '{char_out: 8'hFF, last: 1'b1, empty_line: 1'b0, overflowed: 1'b0};

   typedef struct packed {
      logic             action;
      logic [7:0]       key;
      logic [7:0]       reps;
      logic             fixed;
      cle_pkg::rsp_type want;
   } script_row_type;

   localparam int SCRIPT_ROWS = 25;
   localparam script_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{ACT_EOL, 8'h00,              8'd1,  1'b1, RSP_EMPTY},  // empty line out of reset
      '{ACT_KEY, cle_pkg::KEY_LEFT,  8'd1,  1'b0, RSP_EMPTY},  // left at left end
      '{ACT_KEY, cle_pkg::KEY_BACK,  8'd1,  1'b0, RSP_EMPTY},  // delete at left end
      '{ACT_KEY, cle_pkg::KEY_RIGHT, 8'd1,  1'b0, RSP_EMPTY},  // right at right end
      '{ACT_EOL, 8'hFF,              8'd1,  1'b1, RSP_EMPTY},  // key_code ignored on eol
      '{ACT_KEY, 8'h00,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_EOL, 8'h00,              8'd1,  1'b1, RSP_ONE_00},
      '{ACT_KEY, 8'hFF,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_EOL, 8'h00,              8'd1,  1'b1, RSP_ONE_FF},
      '{ACT_KEY, 8'h61,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, 8'h62,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, 8'h63,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, cle_pkg::KEY_LEFT,  8'd2,  1'b0, RSP_EMPTY},
      '{ACT_KEY, 8'h0A,              8'd1,  1'b0, RSP_EMPTY},  // control byte inserted
      '{ACT_KEY, cle_pkg::KEY_RIGHT, 8'd3,  1'b0, RSP_EMPTY},
      '{ACT_KEY, cle_pkg::KEY_BACK,  8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, cle_pkg::KEY_LEFT,  8'd4,  1'b0, RSP_EMPTY},
      '{ACT_KEY, cle_pkg::KEY_BACK,  8'd1,  1'b0, RSP_EMPTY},
      '{ACT_EOL, 8'h00,              8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, 8'h55,              8'd64, 1'b0, RSP_EMPTY},  // fill the buffer
      '{ACT_KEY, 8'hAA,              8'd2,  1'b0, RSP_EMPTY},  // dropped, sets overflow
      '{ACT_KEY, cle_pkg::KEY_LEFT,  8'd3,  1'b0, RSP_EMPTY},
      '{ACT_KEY, cle_pkg::KEY_BACK,  8'd1,  1'b0, RSP_EMPTY},
      '{ACT_KEY, 8'h11,              8'd1,  1'b0, RSP_EMPTY},  // room again after delete
      '{ACT_EOL, 8'h00,              8'd1,  1'b0, RSP_EMPTY}
   };

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_stall;
   cle_pkg::req_type req_data;
   logic             rsp_valid;
   logic             rsp_stall;
   cle_pkg::rsp_type rsp_data;

   cursor_line_editor_top #(.LINE_DEPTH(LINE_DEPTH)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // gap buffer predictor: head holds chars left of the cursor from index 0,
   // tail holds chars right of it packed against the top of the store
   logic [7:0] gap_mem [LINE_DEPTH];
   logic [6:0] head_chars;
   logic [6:0] tail_chars;
   logic       overflow_sticky;

   cle_pkg::rsp_type emitted [$];
   cle_pkg::rsp_type line_chars_due [$];

   bit         calm;
   bit         hold_due;
   int         errors;
   int         beats_in;
   int         results_seen;
   int         cycles;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("cursor_line_editor_top_test: errors");
         $finish;
      end
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      if (errors < 40)
         $display("result %0d: %s got 0x%0h, want 0x%0h", results_seen, what, got, want);
      errors++;
   endtask

   // apply one accepted beat to the predictor; any line it emits lands in emitted
   task automatic edit_model(input cle_pkg::req_type b);
      int total;
      int k;
      emitted.delete();
      if (b.action == ACT_EOL) begin
         total = head_chars + tail_chars;
         if (total == 0) begin
            emitted.insert(emitted.size(), '{char_out: 8'h00, last: 1'b1, empty_line: 1'b1,
                                             overflowed: overflow_sticky});
         end else begin
            for (k = 0; k < head_chars; k++)
               emitted.insert(emitted.size(), '{char_out: gap_mem[k],
                                                last: (k + 1 == total),
                                                empty_line: 1'b0,
                                                overflowed: overflow_sticky});
            for (k = LINE_DEPTH - tail_chars; k < LINE_DEPTH; k++)
               emitted.insert(emitted.size(), '{char_out: gap_mem[k],
                                                last: (emitted.size() + 1 == total),
                                                empty_line: 1'b0,
                                                overflowed: overflow_sticky});
         end
         head_chars      = '0;
         tail_chars      = '0;
         overflow_sticky = 1'b0;
      end else if (b.key_code == cle_pkg::KEY_LEFT) begin
         if (head_chars != 0) begin
            gap_mem[LINE_DEPTH - tail_chars - 1] = gap_mem[head_chars - 1];
            head_chars--;
            tail_chars++;
         end
      end else if (b.key_code == cle_pkg::KEY_RIGHT) begin
         if (tail_chars != 0) begin
            gap_mem[head_chars] = gap_mem[LINE_DEPTH - tail_chars];
            head_chars++;
            tail_chars--;
         end
      end else if (b.key_code == cle_pkg::KEY_BACK) begin
         if (head_chars != 0)
            head_chars--;
      end else if (head_chars + tail_chars < LINE_DEPTH) begin
         gap_mem[head_chars] = b.key_code;
         head_chars++;
      end else begin
         overflow_sticky = 1'b1;
      end
   endtask

   // offer one beat, hold it through stalls, then book its expected results
   task automatic feed_beat(input cle_pkg::req_type b, input bit fixed,
                            input cle_pkg::rsp_type want);
      while (!calm && $urandom_range(0, 99) < 26) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= b;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      beats_in++;
      edit_model(b);
      if (fixed)
         line_chars_due.insert(line_chars_due.size(), want);
      else
         foreach (emitted[i])
            line_chars_due.insert(line_chars_due.size(), emitted[i]);
   endtask

   task automatic feed_key(input logic [7:0] k);
      feed_beat('{action: ACT_KEY, key_code: k}, 1'b0, RSP_EMPTY);
   endtask

   task automatic feed_eol();
      feed_beat('{action: ACT_EOL, key_code: 8'($urandom_range(0, 255))}, 1'b0, RSP_EMPTY);
   endtask

   function automatic logic [7:0] plain_char();
      logic [7:0] k;
      do
         k = 8'($urandom_range(0, 255));
      while (k == cle_pkg::KEY_LEFT || k == cle_pkg::KEY_RIGHT || k == cle_pkg::KEY_BACK);
      return k;
   endfunction

   function automatic logic [7:0] any_key();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 15)
         return cle_pkg::KEY_LEFT;
      else if (pick < 30)
         return cle_pkg::KEY_RIGHT;
      else if (pick < 42)
         return cle_pkg::KEY_BACK;
      return 8'($urandom_range(0, 255));
   endfunction

   // response checker
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (line_chars_due.size() == 0) begin
            report_mismatch("beat with nothing expected, char_out", rsp_data.char_out, 0);
         end else begin
            if (rsp_data.char_out !== line_chars_due[0].char_out)
               report_mismatch("char_out", rsp_data.char_out, line_chars_due[0].char_out);
            if (rsp_data.last !== line_chars_due[0].last)
               report_mismatch("last", rsp_data.last, line_chars_due[0].last);
            if (rsp_data.empty_line !== line_chars_due[0].empty_line)
               report_mismatch("empty_line", rsp_data.empty_line,
                               line_chars_due[0].empty_line);
            if (rsp_data.overflowed !== line_chars_due[0].overflowed)
               report_mismatch("overflowed", rsp_data.overflowed,
                               line_chars_due[0].overflowed);
            void'(line_chars_due.pop_front());
         end
         results_seen++;
      end
   end

   // response side: random stalls plus one long hold-off
   initial begin : receiver
      int hold_left;
      bit hold_used;
      hold_left = 0;
      hold_used = 1'b0;
      rsp_stall = 1'b0;
      @(posedge clock);
      while (reset)
         @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_due && !hold_used && rsp_valid) begin
            hold_used = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= !calm && ($urandom_range(0, 99) < 26);
         end
      end
   end

   initial begin : sender
      int random_start;
      int line_no;
      int kind;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      head_chars      = '0;
      tail_chars      = '0;
      overflow_sticky = 1'b0;
      calm            = 1'b0;
      hold_due        = 1'b0;
      line_no         = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[r])
         repeat (SCRIPT[r].reps)
            feed_beat('{action: SCRIPT[r].action, key_code: SCRIPT[r].key},
                      SCRIPT[r].fixed, SCRIPT[r].want);

      random_start = beats_in;
      hold_due     = 1'b1;
      while (beats_in - random_start < RANDOM_BEATS) begin
         calm = (beats_in - random_start >= 200) && (beats_in - random_start < 300);
         kind = $urandom_range(0, 99);
         if (line_no == 0 || kind < 5) begin
            // overfill, then either edit a little or delete everything
            repeat (LINE_DEPTH + $urandom_range(1, 4)) feed_key(plain_char());
            if (line_no == 0 || $urandom_range(0, 1) == 1)
               repeat (LINE_DEPTH + 2) feed_key(cle_pkg::KEY_BACK);
            else
               repeat ($urandom_range(0, 6)) feed_key(any_key());
            feed_eol();
         end else if (kind < 13) begin
            repeat ($urandom_range(1, 8))
               feed_beat('{action: ($urandom_range(0, 9) == 0),
                           key_code: 8'($urandom_range(0, 255))}, 1'b0, RSP_EMPTY);
         end else begin
            repeat ($urandom_range(0, 12)) feed_key(any_key());
            feed_eol();
         end
         line_no++;
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (line_chars_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("cursor_line_editor_top_test: clean");
      else
         $display("cursor_line_editor_top_test: errors");
      $finish;
   end

endmodule
